/* rtl/rcbt_pkg.sv */
package rcbt_pkg;

  localparam int unsigned MaxCells = 64;
  localparam int unsigned AddrW    = $clog2(MaxCells);
  localparam int unsigned CountW   = AddrW + 1;
  localparam int unsigned DimW     = 4;
  localparam int unsigned MaxDim   = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegNumCols = 1'b0;
  localparam logic [CfgIdxW-1:0] RegNumRows = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             message_end;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_block_last;
    logic             out_message_last;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             clear;
  } store_req_t;

endpackage

/* rtl/rcbt_store.sv */
module rcbt_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcbt_pkg::store_req_t req_i,
  output logic [7:0]          rdata_o
);
  import rcbt_pkg::*;

  logic [ByteW-1:0] mem [MaxCells];
  logic [MaxCells-1:0] vld_q;
  logic [ByteW-1:0] rdata_q;
  logic             rvld_q;

  // byte storage, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // per-entry valid bits, unwritten cells read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

/* rtl/row_column_block_transposer.sv */
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   in_data_i  (data_byte, message_end)
// out      output     out_valid_o / out_ready_i out_data_o (out_byte, block/message last)
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// bytes are taken one per cycle while a block fills
// a full block, or a byte marked message_end, starts a readout of rows*cols memory reads
// (one memory read per cycle while the output queue has room) during which no input is taken
// readout reads are paced by a two-entry output queue, so out_ready_i low stalls reads
// after reset the store reads as all zero; valid bits clear it again after each block
module row_column_block_transposer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rcbt_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rcbt_pkg::out_t      out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [3:0]          cfg_data_i
);
  import rcbt_pkg::*;

  typedef enum logic {StFill, StDrain} state_e;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    if (v == '0) begin
      return DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      return DimW'(MaxDim);
    end
    return v;
  endfunction

  logic [DimW-1:0] num_cols_q, num_rows_q;
  logic [DimW-1:0] cols, rows;
  logic [CountW-1:0] cells;

  state_e state_q, state_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [DimW-1:0] col_q, col_d, row_q, row_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic end_q, end_d;
  logic rd_pend_q, rd_pend_d;
  logic rd_blast_q, rd_blast_d;
  logic rd_mlast_q, rd_mlast_d;

  store_req_t store_req;
  logic [ByteW-1:0] store_rdata;

  out_t fifo_q [2];
  logic rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q;
  logic [2:0] credit;
  logic push, pop, issue, accept, emit, last_cell;
  logic [CountW-1:0] pos1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= DimW'(MaxDim);
      num_rows_q <= DimW'(MaxDim);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNumCols: num_cols_q <= cfg_data_i;
        RegNumRows: num_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cols  = clamp_dim(num_cols_q);
  assign rows  = clamp_dim(num_rows_q);
  assign cells = CountW'(cols) * CountW'(rows);

  assign in_ready_o = (state_q == StFill);
  assign accept     = in_valid_i && in_ready_o;
  assign pos1       = fill_q + CountW'(1);
  assign emit       = !(pos1 < cells) || in_data_i.message_end;

  assign pop    = out_valid_o && out_ready_i;
  assign push   = rd_pend_q;
  assign credit = 3'(cnt_q) + 3'(rd_pend_q) - 3'(pop);
  assign issue  = (state_q == StDrain) && (credit < 3'd2);
  assign last_cell = (col_q == cols - DimW'(1)) && (row_q == rows - DimW'(1));

  always_comb begin
    store_req       = '0;
    store_req.we    = accept && (fill_q < cells);
    store_req.waddr = fill_q[AddrW-1:0];
    store_req.wdata = in_data_i.data_byte;
    store_req.re    = issue;
    store_req.raddr = addr_q;
    store_req.clear = issue && last_cell;
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    col_d      = col_q;
    row_d      = row_q;
    addr_d     = addr_q;
    end_d      = end_q;
    rd_pend_d  = issue;
    rd_blast_d = rd_blast_q;
    rd_mlast_d = rd_mlast_q;
    unique case (state_q)
      StFill: begin
        if (accept) begin
          if (emit) begin
            state_d = StDrain;
            fill_d  = '0;
            col_d   = '0;
            row_d   = '0;
            addr_d  = '0;
            end_d   = in_data_i.message_end;
          end else begin
            fill_d = pos1;
          end
        end
      end
      StDrain: begin
        if (issue) begin
          rd_blast_d = last_cell;
          rd_mlast_d = last_cell && end_q;
          if (last_cell) begin
            state_d = StFill;
          end else if (row_q == rows - DimW'(1)) begin
            row_d  = '0;
            col_d  = col_q + DimW'(1);
            addr_d = AddrW'(col_q) + AddrW'(1);
          end else begin
            row_d  = row_q + DimW'(1);
            addr_d = addr_q + AddrW'(cols);
          end
        end
      end
      default: state_d = StFill;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StFill;
      fill_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      addr_q     <= '0;
      end_q      <= 1'b0;
      rd_pend_q  <= 1'b0;
      rd_blast_q <= 1'b0;
      rd_mlast_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      col_q      <= col_d;
      row_q      <= row_d;
      addr_q     <= addr_d;
      end_q      <= end_d;
      rd_pend_q  <= rd_pend_d;
      rd_blast_q <= rd_blast_d;
      rd_mlast_q <= rd_mlast_d;
    end
  end

  rcbt_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  // two-entry output queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{out_byte: store_rdata, out_block_last: rd_blast_q,
                            out_message_last: rd_mlast_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = fifo_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (cnt_q != 2'd2 || pop))
    else $error("output queue overflow");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CountW'(MaxCells))
    else $error("fill count out of range");

  a_msg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_message_last) |-> out_data_o.out_block_last)
    else $error("message last without block last");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last_cell) |=> (state_q == StFill && rd_blast_q))
    else $error("readout did not close the block");
`endif

endmodule
